// ----- hw/rtl/http_get_request_header_parser_core_defines.svh -----
// ---------------------------------------------------------------------------
// HTTP GET request header parser - assertion macros
// Concurrent check wrappers; defining NO_ASSERTIONS turns them into nothing.
// ---------------------------------------------------------------------------
`ifndef HTTP_GET_REQUEST_HEADER_PARSER_CORE_DEFINES_SVH
`define HTTP_GET_REQUEST_HEADER_PARSER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define HGRHP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define HGRHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HGRHP_ASSERT(label, clk, rst, prop, msg)
`define HGRHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/hgrhp_pkg.sv -----
// ---------------------------------------------------------------------------
// HTTP GET request header parser - package
// Shared constants, header name tables and the result item type.
// ---------------------------------------------------------------------------
`default_nettype none

package hgrhp_pkg;

  localparam int HOST_CAPACITY_DEF = 128;
  localparam int PATH_CAPACITY_DEF = 256;

  typedef logic [7:0] byte_t;

  localparam byte_t CHAR_CR  = 8'h0D;
  localparam byte_t CHAR_LF  = 8'h0A;
  localparam byte_t CHAR_SP  = 8'h20;
  localparam byte_t CHAR_TAB = 8'h09;

  // write kinds on the result item
  localparam logic [1:0] WK_NONE = 2'd0;
  localparam logic [1:0] WK_PATH = 2'd1;
  localparam logic [1:0] WK_HOST = 2'd2;

  typedef enum logic [1:0] {
    HK_NONE,
    HK_HOST,
    HK_ACCEPT,
    HK_SIG
  } hkind_t;

  localparam byte_t GET_WORD    [4]  = '{"G", "E", "T", " "};
  localparam byte_t HOST_NAME   [5]  = '{"h", "o", "s", "t", ":"};
  localparam byte_t ACCEPT_NAME [16] = '{"a", "c", "c", "e", "p", "t", "-", "e",
                                         "n", "c", "o", "d", "i", "n", "g", ":"};
  localparam byte_t SIG_NAME    [13] = '{"x", "-", "q", "o", "s", "-", "p", "q",
                                         "-", "s", "i", "g", ":"};

  localparam int HIST_LEN = 13;

  // tokens packed with the last character in the low byte (newest history byte)
  localparam logic [4*8-1:0]  TOK_GZIP   = "gzip";
  localparam logic [13*8-1:0] TOK_FIRST  = "mldsa65-first";
  localparam logic [6*8-1:0]  TOK_PREFER = "prefer";

  typedef struct packed {
    logic [1:0] write_kind;
    logic [7:0] write_index;
    logic [7:0] write_byte;
    logic       summary_valid;
    logic       host_missing;
    logic       accepts_gzip;
    logic       prefers_pq_signature;
    logic [6:0] host_length;
    logic [7:0] path_length;
  } result_t;

  function automatic byte_t to_lower(input byte_t c);
    if (c >= "A" && c <= "Z") begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic [4:0] name_len(input hkind_t kind);
    unique case (kind)
      HK_HOST:   return 5'd5;
      HK_ACCEPT: return 5'd16;
      HK_SIG:    return 5'd13;
      default:   return 5'd0;
    endcase
  endfunction

  // caller guarantees col < name_len(kind)
  function automatic byte_t name_char(input hkind_t kind, input logic [4:0] col);
    unique case (kind)
      HK_HOST:   return HOST_NAME[col[2:0]];
      HK_ACCEPT: return ACCEPT_NAME[col[3:0]];
      HK_SIG:    return SIG_NAME[col[3:0]];
      default:   return 8'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/http_get_request_header_parser_core.sv -----
// ---------------------------------------------------------------------------
// HTTP GET request header parser core
// Takes an HTTP request one byte per item and ends it at end_of_request. A
// first line opening with "GET " has its path (up to a space or line end)
// written out byte by byte as path items, at most PATH_CAPACITY-1 of them.
// A case-insensitive "host:" line has its value written as host items with
// leading blanks dropped, at most HOST_CAPACITY-1 bytes; trailing blanks are
// written but left out of host_length, and a later Host line replaces an
// earlier one. "accept-encoding:" values holding "gzip" and "x-qos-pq-sig:"
// values holding "mldsa65-first" or "prefer" raise the two flags. Every input
// item gives exactly one result item; the one for the final byte carries the
// summary, after which the parser is back in its reset state. Throughput is
// one byte per clock while in_stall is low; results go to the single result
// register. A one-entry skid register behind it lets a byte be taken while a
// result waits; in_stall rises only when both are full.
// ---------------------------------------------------------------------------
`default_nettype none

`include "http_get_request_header_parser_core_defines.svh"

module http_get_request_header_parser_core #(
  parameter int HOST_CAPACITY = hgrhp_pkg::HOST_CAPACITY_DEF,
  parameter int PATH_CAPACITY = hgrhp_pkg::PATH_CAPACITY_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_request,
  // output channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      write_kind,
  output logic [7:0]      write_index,
  output logic [7:0]      write_byte,
  output logic            summary_valid,
  output logic            host_missing,
  output logic            accepts_gzip,
  output logic            prefers_pq_signature,
  output logic [6:0]      host_length,
  output logic [7:0]      path_length
);

  import hgrhp_pkg::*;

  localparam int HW = $clog2(HOST_CAPACITY);
  localparam int PW = $clog2(PATH_CAPACITY);
  localparam logic [HW-1:0] HOST_LAST = HW'(HOST_CAPACITY - 1);
  localparam logic [PW-1:0] PATH_LAST = PW'(PATH_CAPACITY - 1);

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_PATH,
    PH_REST_FIRST,
    PH_NAME,
    PH_HOST_VALUE,
    PH_TOKEN_VALUE,
    PH_SKIP
  } phase_t;

  // parser state
  phase_t                   phase,               phase_next;
  logic [4:0]               column_count,        column_count_next;
  hkind_t                   header_kind,         header_kind_next;
  logic [HIST_LEN*8-1:0]    history,             history_next;
  logic [HW-1:0]            host_write_count,    host_write_count_next;
  logic [HW-1:0]            host_trimmed_length, host_trimmed_length_next;
  logic [PW-1:0]            path_count,          path_count_next;
  logic                     flag_gzip,           flag_gzip_next;
  logic                     flag_pq,             flag_pq_next;

  // result register and skid entry
  result_t                  out_item;
  result_t                  skid_item;
  logic                     skid_valid;

  result_t                  res;
  byte_t                    lc;
  logic                     blank;
  hkind_t                   kind_eff;
  logic [4:0]               col_inc;
  logic                     accept_in;

  assign in_stall  = skid_valid;
  assign accept_in = in_valid && !skid_valid;

  assign lc      = to_lower(data_byte);
  assign blank   = (data_byte == CHAR_SP) || (data_byte == CHAR_TAB);
  assign col_inc = column_count + 5'd1;

  // first column of a header line picks the candidate name
  always_comb begin
    kind_eff = header_kind;
    if (column_count == 5'd0) begin
      unique case (lc)
        "h":     kind_eff = HK_HOST;
        "a":     kind_eff = HK_ACCEPT;
        "x":     kind_eff = HK_SIG;
        default: kind_eff = HK_NONE;
      endcase
    end
  end

  always_comb begin
    phase_next               = phase;
    column_count_next        = column_count;
    header_kind_next         = header_kind;
    history_next             = history;
    host_write_count_next    = host_write_count;
    host_trimmed_length_next = host_trimmed_length;
    path_count_next          = path_count;
    flag_gzip_next           = flag_gzip;
    flag_pq_next             = flag_pq;
    res                      = '0;

    if (data_byte == CHAR_CR || data_byte == CHAR_LF) begin
      // any line break run starts a fresh header line
      phase_next        = PH_NAME;
      column_count_next = 5'd0;
      header_kind_next  = HK_NONE;
    end else begin
      unique case (phase)
        PH_METHOD: begin
          if (column_count < 5'd4 && data_byte == GET_WORD[column_count[1:0]]) begin
            column_count_next = col_inc;
            if (col_inc == 5'd4) begin
              phase_next = PH_PATH;
            end
          end else begin
            phase_next = PH_REST_FIRST;
          end
        end
        PH_PATH: begin
          if (data_byte == CHAR_SP) begin
            phase_next = PH_REST_FIRST;
          end else if (path_count < PATH_LAST) begin
            res.write_kind  = WK_PATH;
            res.write_index = 8'(path_count);
            res.write_byte  = data_byte;
            path_count_next = path_count + PW'(1);
          end
        end
        PH_NAME: begin
          header_kind_next = kind_eff;
          if (kind_eff != HK_NONE && column_count < name_len(kind_eff) &&
              lc == name_char(kind_eff, column_count)) begin
            column_count_next = col_inc;
            if (col_inc == name_len(kind_eff)) begin
              if (kind_eff == HK_HOST) begin
                host_write_count_next    = '0;
                host_trimmed_length_next = '0;
                phase_next               = PH_HOST_VALUE;
              end else begin
                history_next = '0;
                phase_next   = PH_TOKEN_VALUE;
              end
            end
          end else begin
            phase_next = PH_SKIP;
          end
        end
        PH_HOST_VALUE: begin
          if (blank && host_write_count == '0) begin
            // leading blank dropped
          end else if (host_write_count < HOST_LAST) begin
            res.write_kind        = WK_HOST;
            res.write_index       = 8'(host_write_count);
            res.write_byte        = data_byte;
            host_write_count_next = host_write_count + HW'(1);
            if (!blank) begin
              host_trimmed_length_next = host_write_count + HW'(1);
            end
          end else if (!blank) begin
            host_trimmed_length_next = HOST_LAST;
          end
        end
        PH_TOKEN_VALUE: begin
          history_next = {history[(HIST_LEN-1)*8-1:0], lc};
          if (header_kind == HK_ACCEPT) begin
            if (history_next[4*8-1:0] == TOK_GZIP) begin
              flag_gzip_next = 1'b1;
            end
          end else if (header_kind == HK_SIG) begin
            if (history_next == TOK_FIRST || history_next[6*8-1:0] == TOK_PREFER) begin
              flag_pq_next = 1'b1;
            end
          end
        end
        default: begin
          // rest of first line, or a line being skipped
        end
      endcase
    end

    if (end_of_request) begin
      res.summary_valid        = 1'b1;
      res.host_missing         = (host_trimmed_length_next == '0);
      res.accepts_gzip         = flag_gzip_next;
      res.prefers_pq_signature = flag_pq_next;
      res.host_length          = 7'(host_trimmed_length_next);
      res.path_length          = 8'(path_count_next);
      // back to reset for the next request
      phase_next               = PH_METHOD;
      column_count_next        = 5'd0;
      header_kind_next         = HK_NONE;
      history_next             = '0;
      host_write_count_next    = '0;
      host_trimmed_length_next = '0;
      path_count_next          = '0;
      flag_gzip_next           = 1'b0;
      flag_pq_next             = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_METHOD;
      column_count        <= 5'd0;
      header_kind         <= HK_NONE;
      history             <= '0;
      host_write_count    <= '0;
      host_trimmed_length <= '0;
      path_count          <= '0;
      flag_gzip           <= 1'b0;
      flag_pq             <= 1'b0;
      out_valid           <= 1'b0;
      skid_valid          <= 1'b0;
    end else begin
      if (accept_in) begin
        phase               <= phase_next;
        column_count        <= column_count_next;
        header_kind         <= header_kind_next;
        history             <= history_next;
        host_write_count    <= host_write_count_next;
        host_trimmed_length <= host_trimmed_length_next;
        path_count          <= path_count_next;
        flag_gzip           <= flag_gzip_next;
        flag_pq             <= flag_pq_next;
      end
      if (out_valid && out_stall) begin
        // result held; a new item parks in the skid entry
        if (accept_in) begin
          skid_item  <= res;
          skid_valid <= 1'b1;
        end
      end else if (skid_valid) begin
        out_item   <= skid_item;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept_in) begin
        out_item  <= res;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign write_kind           = out_item.write_kind;
  assign write_index          = out_item.write_index;
  assign write_byte           = out_item.write_byte;
  assign summary_valid        = out_item.summary_valid;
  assign host_missing         = out_item.host_missing;
  assign accepts_gzip         = out_item.accepts_gzip;
  assign prefers_pq_signature = out_item.prefers_pq_signature;
  assign host_length          = out_item.host_length;
  assign path_length          = out_item.path_length;

  // checks
  `HGRHP_ASSERT(a_skid_behind_out, clk, rst,
                !skid_valid || out_valid,
                "skid full with output empty")
  `HGRHP_ASSERT(a_skid_fill_on_stall, clk, rst,
                !$rose(skid_valid) || $past(out_valid && out_stall),
                "skid filled without output stall")
  `HGRHP_ASSERT(a_trim_within_count, clk, rst,
                host_trimmed_length <= host_write_count,
                "host trimmed length beyond written count")
  `HGRHP_ASSERT_NEXT(a_end_resets, clk, rst,
                     accept_in && end_of_request,
                     phase == PH_METHOD && path_count == '0 &&
                     host_trimmed_length == '0 && !flag_gzip && !flag_pq,
                     "parser state not reset after final byte")

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// HTTP GET request header parser - testbench
// Feeds directed and random requests to the parser, one byte per item. A
// scoreboard class predicts each result item and compares it field by field.
// Both channels idle and stall at random, with one long output hold-off.
// ---------------------------------------------------------------------------
module testbench;
  import hgrhp_pkg::*;

  localparam int BYTE_TARGET = 1700;
  localparam int HOLD_CYCLES = 60;
  localparam int TAIL_CYCLES = 8;
  localparam int PATH_LIMIT  = PATH_CAPACITY_DEF - 1;
  localparam int HOST_LIMIT  = HOST_CAPACITY_DEF - 1;

  // where the parser stands within the current line
  typedef enum logic [2:0] {
    AT_METHOD,
    AT_PATH,
    AT_FIRST_TAIL,
    AT_NAME,
    AT_HOST_VAL,
    AT_TOKEN_VAL,
    AT_IGNORE
  } stage_t;

  // -------------------------------------------------------------------------
  // Scoreboard: own copy of the parser state and a queue of expected results
  // -------------------------------------------------------------------------
  class request_parser_model;
    stage_t                 stage;
    int                     col;
    hkind_t                 hdr;
    logic [HIST_LEN*8-1:0]  tail;        // newest value byte in the low byte
    int                     host_wr;
    int                     host_len;
    int                     path_len;
    bit                     gzip_seen;
    bit                     pq_seen;
    result_t                outcome_q[$];
    int                     failures;

    function new();
      failures = 0;
      restart();
    endfunction

    function void restart();
      stage     = AT_METHOD;
      col       = 0;
      hdr       = HK_NONE;
      tail      = '0;
      host_wr   = 0;
      host_len  = 0;
      path_len  = 0;
      gzip_seen = 1'b0;
      pq_seen   = 1'b0;
    endfunction

    static function int header_len(hkind_t k);
      case (k)
        HK_HOST:   return $size(HOST_NAME);
        HK_ACCEPT: return $size(ACCEPT_NAME);
        HK_SIG:    return $size(SIG_NAME);
        default:   return 0;
      endcase
    endfunction

    // only called with i below header_len(k)
    static function byte_t header_char(hkind_t k, int i);
      case (k)
        HK_HOST:   return HOST_NAME[i];
        HK_ACCEPT: return ACCEPT_NAME[i];
        HK_SIG:    return SIG_NAME[i];
        default:   return 8'd0;
      endcase
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    // one accepted input item -> one expected result item
    function void take_byte(byte_t b, bit last);
      result_t r;
      byte_t   lc;
      bit      blank;
      bit      hit;
      int      nlen;
      r     = '0;
      lc    = (b >= "A" && b <= "Z") ? (b | 8'h20) : b;
      blank = (b == CHAR_SP) || (b == CHAR_TAB);
      if (b == CHAR_CR || b == CHAR_LF) begin
        stage = AT_NAME;
        col   = 0;
        hdr   = HK_NONE;
      end else begin
        case (stage)
          AT_METHOD: begin
            if (b == GET_WORD[col]) begin
              col++;
              if (col == 4) stage = AT_PATH;
            end else begin
              stage = AT_FIRST_TAIL;
            end
          end
          AT_PATH: begin
            if (b == CHAR_SP) begin
              stage = AT_FIRST_TAIL;
            end else if (path_len < PATH_LIMIT) begin
              r.write_kind  = WK_PATH;
              r.write_index = path_len[7:0];
              r.write_byte  = b;
              path_len++;
            end
          end
          AT_NAME: begin
            if (col == 0) begin
              hdr = (lc == "h") ? HK_HOST : (lc == "a") ? HK_ACCEPT :
                    (lc == "x") ? HK_SIG : HK_NONE;
            end
            nlen = header_len(hdr);
            hit  = (col < nlen) && (lc == header_char(hdr, col));
            if (hit) begin
              col++;
              if (col == nlen) begin
                if (hdr == HK_HOST) begin
                  host_wr  = 0;
                  host_len = 0;
                  stage    = AT_HOST_VAL;
                end else begin
                  tail  = '0;
                  stage = AT_TOKEN_VAL;
                end
              end
            end else begin
              stage = AT_IGNORE;
            end
          end
          AT_HOST_VAL: begin
            if (blank && host_wr == 0) begin
              // leading blanks dropped
            end else if (host_wr < HOST_LIMIT) begin
              r.write_kind  = WK_HOST;
              r.write_index = host_wr[7:0];
              r.write_byte  = b;
              host_wr++;
              if (!blank) host_len = host_wr;
            end else if (!blank) begin
              host_len = HOST_LIMIT;
            end
          end
          AT_TOKEN_VAL: begin
            tail = {tail[HIST_LEN*8-9:0], lc};
            if (hdr == HK_ACCEPT && tail[31:0] == TOK_GZIP) gzip_seen = 1'b1;
            if (hdr == HK_SIG && (tail == TOK_FIRST || tail[47:0] == TOK_PREFER))
              pq_seen = 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (last) begin
        r.summary_valid        = 1'b1;
        r.host_missing         = (host_len == 0);
        r.accepts_gzip         = gzip_seen;
        r.prefers_pq_signature = pq_seen;
        r.host_length          = host_len[6:0];
        r.path_length          = path_len[7:0];
        restart();
      end
      outcome_q.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_outcome(result_t got);
      result_t want;
      if (outcome_q.size() == 0) begin
        $error("result item with no expectation pending");
        failures++;
        return;
      end
      want = outcome_q.pop_front();
      compare("write_kind", want.write_kind, got.write_kind);
      compare("write_index", want.write_index, got.write_index);
      compare("write_byte", want.write_byte, got.write_byte);
      compare("summary_valid", want.summary_valid, got.summary_valid);
      compare("host_missing", want.host_missing, got.host_missing);
      compare("accepts_gzip", want.accepts_gzip, got.accepts_gzip);
      compare("prefers_pq_signature", want.prefers_pq_signature,
              got.prefers_pq_signature);
      compare("host_length", want.host_length, got.host_length);
      compare("path_length", want.path_length, got.path_length);
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input has a known value from time 0
  // -------------------------------------------------------------------------
  logic       clk            = 1'b0;
  logic       rst            = 1'b1;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte      = 8'd0;
  logic       end_of_request = 1'b0;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic [1:0] write_kind;
  logic [7:0] write_index;
  logic [7:0] write_byte;
  logic       summary_valid;
  logic       host_missing;
  logic       accepts_gzip;
  logic       prefers_pq_signature;
  logic [6:0] host_length;
  logic [7:0] path_length;

  request_parser_model parser;
  byte_t               req_bytes[$];   // request under construction
  int                  bytes_sent = 0;
  bit                  calm       = 1'b0;  // no idling on either side
  bit                  hold_req   = 1'b0;  // asks the receiver for a long hold-off

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  http_get_request_header_parser_core uut (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .data_byte            (data_byte),
    .end_of_request       (end_of_request),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .write_kind           (write_kind),
    .write_index          (write_index),
    .write_byte           (write_byte),
    .summary_valid        (summary_valid),
    .host_missing         (host_missing),
    .accepts_gzip         (accepts_gzip),
    .prefers_pq_signature (prefers_pq_signature),
    .host_length          (host_length),
    .path_length          (path_length)
  );

  // Monitor: both channels sampled right after the edge, so the values seen
  // are those the edge acted on (all drives here are nonblocking).
  // Input noted before the output check in case the result comes early.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      parser.take_byte(data_byte, end_of_request);
    if (!rst && out_valid && !out_stall)
      parser.check_outcome(result_t'{write_kind, write_index, write_byte,
                                     summary_valid, host_missing, accepts_gzip,
                                     prefers_pq_signature, host_length,
                                     path_length});
  end

  // Receiver: random stalls, none while calm, and one long hold-off on
  // request so the skid entry fills and in_stall goes up.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 29);
        @(posedge clk);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Request construction
  // -------------------------------------------------------------------------

  // any byte but a line end; path bytes also exclude the space
  function automatic byte_t pick_byte(bit for_path);
    byte_t b;
    do
      b = byte_t'($urandom_range(255));
    while (b == CHAR_CR || b == CHAR_LF || (for_path && b == CHAR_SP));
    return b;
  endfunction

  function automatic void add_text(string s, bit mix_case);
    byte_t c;
    int    i;
    for (i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix_case && (c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(1))
        c = c ^ 8'h20;
      req_bytes.push_back(c);
    end
  endfunction

  function automatic void add_blanks(int n);
    int i;
    for (i = 0; i < n; i++) req_bytes.push_back($urandom_range(1) ? CHAR_SP : CHAR_TAB);
  endfunction

  // CR/LF runs, blank lines among them
  function automatic void add_eol();
    case ($urandom_range(4))
      0: req_bytes = {req_bytes, CHAR_CR, CHAR_LF};
      1: req_bytes.push_back(CHAR_LF);
      2: req_bytes.push_back(CHAR_CR);
      3: req_bytes = {req_bytes, CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF};
      default: req_bytes = {req_bytes, CHAR_LF, CHAR_LF};
    endcase
  endfunction

  // header name in random case; a spoilt one breaks off with a wrong char
  function automatic void add_name(hkind_t k, bit spoil);
    int    i;
    int    cut;
    byte_t c;
    cut = spoil ? $urandom_range(request_parser_model::header_len(k) - 1)
                : request_parser_model::header_len(k);
    for (i = 0; i < cut; i++) begin
      c = request_parser_model::header_char(k, i);
      if (c >= "a" && c <= "z" && $urandom_range(1)) c = c ^ 8'h20;
      req_bytes.push_back(c);
    end
    if (spoil) req_bytes.push_back(request_parser_model::header_char(k, cut) ^ 8'h01);
  endfunction

  // long values straddle the host capacity, trailing blanks included
  function automatic void add_host_value(bit long_one);
    int i;
    int n;
    add_blanks($urandom_range(2));
    n = long_one ? $urandom_range(HOST_LIMIT - 6, HOST_LIMIT + 10) : $urandom_range(16);
    for (i = 0; i < n; i++)
      req_bytes.push_back(($urandom_range(3) == 0) ? pick_byte(1'b0)
                                                   : byte_t'($urandom_range(33, 126)));
    add_blanks($urandom_range(3));
  endfunction

  // comma list of hits, near misses and other words
  function automatic void add_token_value(hkind_t k);
    string acc_words[6] = '{"gzip", "deflate", "br", "gzi", "x-gzip", "identity"};
    string sig_words[6] = '{"mldsa65-first", "prefer", "prefe", "mldsa65-firs",
                            "preferred", "none"};
    int    i;
    int    n;
    add_blanks($urandom_range(1));
    n = $urandom_range(1, 3);
    for (i = 0; i < n; i++) begin
      if (i != 0) add_text(", ", 1'b0);
      if ($urandom_range(4) == 0) req_bytes.push_back(pick_byte(1'b0));
      add_text((k == HK_ACCEPT) ? acc_words[$urandom_range(5)] : sig_words[$urandom_range(5)],
               1'b1);
    end
  endfunction

  // mostly well-formed; every 20th has a long path, and every 20th, five later, a long host
  function automatic void build_request(int n);
    string misc[4] = '{"User-Agent: probe", "Accept: gzip", "Connection: close",
                       "X-Trace: prefer"};
    int    sel;
    int    len;
    int    hn;
    int    i;
    int    kind;
    bit    long_host;
    req_bytes.delete();
    sel       = (n % 20 == 3) ? 9 : $urandom_range(9);
    long_host = (n % 20 == 8);
    case (sel)
      0: add_text("POST /form HTTP/1.1", 1'b0);
      1: add_text("get /lower", 1'b0);
      2: add_text("GETX /", 1'b0);
      3: begin
        // looks like a header but sits on the first line
        add_name(HK_HOST, 1'b0);
        add_host_value(1'b0);
      end
      4: begin
        // empty first line
      end
      default: begin
        add_text("GET ", 1'b0);
        len = (n % 20 == 3) ? $urandom_range(PATH_LIMIT - 5, PATH_LIMIT + 40)
                            : $urandom_range(12);
        for (i = 0; i < len; i++) req_bytes.push_back(pick_byte(1'b1));
        if ($urandom_range(1)) add_text(" HTTP/1.1", 1'b0);
      end
    endcase
    hn = long_host ? $urandom_range(1, 4) : $urandom_range(5);
    for (i = 0; i < hn; i++) begin
      add_eol();
      kind = (long_host && i == 0) ? 0 : $urandom_range(5);
      case (kind)
        0, 1: begin
          add_name(HK_HOST, 1'b0);
          add_host_value(long_host && i == 0);
        end
        2: begin
          add_name(HK_ACCEPT, 1'b0);
          add_token_value(HK_ACCEPT);
        end
        3: begin
          add_name(HK_SIG, 1'b0);
          add_token_value(HK_SIG);
        end
        4: add_text(misc[$urandom_range(3)], 1'b0);
        default: begin
          add_name(hkind_t'($urandom_range(1, 3)), 1'b1);
          add_text(" gzip prefer", 1'b0);
        end
      endcase
    end
    if (req_bytes.size() == 0 || $urandom_range(9) < 7) add_eol();
  endfunction

  // line ends, spaces and arbitrary bytes
  function automatic void build_noise();
    int i;
    int n;
    req_bytes.delete();
    n = $urandom_range(1, 30);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: req_bytes.push_back(CHAR_CR);
        1: req_bytes.push_back(CHAR_LF);
        2: req_bytes.push_back(CHAR_SP);
        default: req_bytes.push_back(byte_t'($urandom_range(255)));
      endcase
    end
  endfunction

  // -------------------------------------------------------------------------
  // Driving
  // -------------------------------------------------------------------------

  // one item: random idle first, then hold it until it is taken
  task automatic push_byte(byte_t b, bit last);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= b;
    end_of_request <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // the request's last byte carries end_of_request
  task automatic send_request();
    int i;
    for (i = 0; i < req_bytes.size(); i++) push_byte(req_bytes[i], i == req_bytes.size() - 1);
  endtask

  // sender goes quiet until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do
      @(posedge clk);
    while (parser.pending() != 0);
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    int req_no;
    parser = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // NUL and 0xFF in the path, request ends mid-path, no host
    req_bytes = '{"G", "E", "T", " ", "/", 8'h00, 8'hFF};
    send_request();
    // first line empty; host value with leading tab/space and a trailing blank
    req_bytes = '{CHAR_LF, "h", "o", "S", "T", ":", CHAR_TAB, CHAR_SP, "a", CHAR_SP};
    send_request();
    // single byte request, no method
    req_bytes = '{"X"};
    send_request();
    // header-looking first line ignored; an empty Host line wipes the earlier one
    req_bytes.delete();
    add_text("Host:z", 1'b0);
    req_bytes.push_back(CHAR_LF);
    add_text("host:q", 1'b0);
    req_bytes = {req_bytes, CHAR_CR, CHAR_LF};
    add_text("HOST:", 1'b0);
    send_request();
    drain();

    // random requests with a calm stretch, one output hold-off and one drain
    req_no = 0;
    while (bytes_sent < BYTE_TARGET) begin
      calm = (req_no >= 10 && req_no < 16);
      if (req_no == 6) hold_req = 1'b1;
      if (req_no == 20) drain();
      if (req_no % 20 == 3 || req_no % 20 == 8 || $urandom_range(9) < 8)
        build_request(req_no);
      else
        build_noise();
      send_request();
      req_no++;
    end
    calm = 1'b0;
    drain();

    // let anything stray show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (parser.failures == 0 && parser.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
